@@ hdl/nibble_wildcard_byte_pattern_matcher_defines.svh @@
// Assertion macros for the nibble wildcard byte pattern matcher.
`ifndef NIBBLE_WILDCARD_BYTE_PATTERN_MATCHER_DEFINES_SVH
`define NIBBLE_WILDCARD_BYTE_PATTERN_MATCHER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define NWBPM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nwbpm assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define NWBPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nwbpm assertion failed");
`else
`define NWBPM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define NWBPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/nwbpm_pkg.sv @@
// Shared types and constants for the nibble wildcard byte pattern matcher.
`default_nettype none
package nwbpm_pkg;
	// Default window depth in bytes
	localparam int MAX_PATTERN_BYTES_DEF = 8;
	// Signature slots held by the pattern register (64 bits / 8)
	localparam int PAT_SLOTS = 8;
	localparam int PAT_SEL_W = $clog2(PAT_SLOTS);
	localparam int LEN_W = 4;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 64;

	// Register indexes (paddr[4:3])
	localparam logic [1:0] REG_PATTERN_BYTES = 2'd0;
	localparam logic [1:0] REG_NIBBLE_WILDCARDS = 2'd1;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;
	localparam logic [1:0] REG_PATTERN_VALID = 2'd3;

	// Nibble keep masks
	localparam logic [7:0] NIBBLE_LO_MASK = 8'h0F;
	localparam logic [7:0] NIBBLE_HI_MASK = 8'hF0;

	typedef struct packed {
		logic [63:0] pattern_bytes;
		logic [15:0] nibble_wildcards;
		logic [LEN_W-1:0] pattern_length;
		logic pattern_valid;
	} cfg_t;
endpackage
`default_nettype wire

@@ hdl/nibble_wildcard_byte_pattern_matcher.sv @@
// Top level of the nibble wildcard byte pattern matcher.
`default_nettype none
`include "nibble_wildcard_byte_pattern_matcher_defines.svh"
// Scans a byte stream for a signature of up to MAX_PATTERN_BYTES bytes in
// which any nibble may be a wildcard. Every input beat yields one output beat
// carrying a match flag and the byte's index since the last restart. One byte
// is taken per clock unless the output stalls; its result is registered and
// appears in the cycle after acceptance. The window is a row of cells that
// shift one byte per beat and compare their slots in parallel; the AND of all
// cell hits and the fill check feeds the output register. Configuration writes
// via APB at byte addresses 0, 8, 16 and 24 take effect on the next beat.
module nibble_wildcard_byte_pattern_matcher #(
	parameter int MAX_PATTERN_BYTES = nwbpm_pkg::MAX_PATTERN_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	// APB configuration port
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [nwbpm_pkg::APB_ADDR_W-1:0] paddr,
	input wire logic [nwbpm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [nwbpm_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	// Input stream
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata, // [7:0] data_byte
	input wire logic s_tuser, // [0] restart
	// Result stream
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [39:0] m_tdata // [0] match, [32:1] byte_index, [39:33] zero
);
	localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

	nwbpm_pkg::cfg_t cfg;
	logic [nwbpm_pkg::LEN_W-1:0] len;
	logic accept;
	logic restart;
	logic [7:0] win [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0] hits;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_next;
	logic [31:0] pos_q;
	logic [31:0] idx;
	logic hit;
	logic m_tvalid_q;
	logic m_match_q;
	logic [31:0] m_index_q;

	nwbpm_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	// Effective length: zero reads as one, clamp to window depth
	always_comb begin
		if (cfg.pattern_length == '0) begin
			len = nwbpm_pkg::LEN_W'(1);
		end else if (cfg.pattern_length > nwbpm_pkg::LEN_W'(MAX_PATTERN_BYTES)) begin
			len = nwbpm_pkg::LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			len = cfg.pattern_length;
		end
	end

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign restart = s_tuser;

	// Cell row: cell 0 takes the new byte, cell k takes cell k-1
	for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
		if (k == 0) begin : g_head
			nwbpm_cell #(.CELL_INDEX(k)) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift_en(accept),
				.clear(1'b0),
				.byte_in(s_tdata),
				.len(len),
				.pattern_bytes(cfg.pattern_bytes),
				.nibble_wildcards(cfg.nibble_wildcards),
				.byte_out(win[k]),
				.hit(hits[k])
			);
		end else begin : g_body
			nwbpm_cell #(.CELL_INDEX(k)) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.shift_en(accept),
				.clear(restart),
				.byte_in(win[k-1]),
				.len(len),
				.pattern_bytes(cfg.pattern_bytes),
				.nibble_wildcards(cfg.nibble_wildcards),
				.byte_out(win[k]),
				.hit(hits[k])
			);
		end
	end

	// Fill level and byte index for this beat
	always_comb begin
		if (restart) begin
			fill_next = FILL_W'(1);
			idx = '0;
		end else begin
			fill_next = (fill_q < FILL_W'(MAX_PATTERN_BYTES)) ? fill_q + FILL_W'(1) : fill_q;
			idx = pos_q;
		end
		hit = cfg.pattern_valid && (nwbpm_pkg::LEN_W'(fill_next) >= len) && (&hits);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			fill_q <= fill_next;
			pos_q <= idx + 32'd1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_match_q <= hit;
			m_index_q <= idx;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {7'b0, m_index_q, m_match_q};

	// Checks
	`NWBPM_ASSERT_NEXT(a_beat_gives_result, clk, arst_n, accept, m_tvalid_q)
	`NWBPM_ASSERT_NEXT(a_restart_index_zero, clk, arst_n, accept && restart, m_index_q == 32'd0)
	`NWBPM_ASSERT_NEXT(a_index_follows, clk, arst_n, accept && !restart, m_index_q == $past(pos_q))
	`NWBPM_ASSERT_SAME(a_match_needs_valid, clk, arst_n, m_tvalid_q && m_match_q, cfg.pattern_valid)
	`NWBPM_ASSERT_SAME(a_fill_bounded, clk, arst_n, 1'b1, fill_q <= FILL_W'(MAX_PATTERN_BYTES))
endmodule
`default_nettype wire

@@ hdl/nwbpm_regs.sv @@
// APB configuration register file for the pattern matcher.
`default_nettype none
module nwbpm_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [nwbpm_pkg::APB_ADDR_W-1:0] paddr,
	input wire logic [nwbpm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [nwbpm_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	output nwbpm_pkg::cfg_t cfg
);
	nwbpm_pkg::cfg_t cfg_q;
	logic wr_en;
	logic [1:0] reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign reg_sel = paddr[4:3];
	assign cfg = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes <= '0;
			cfg_q.nibble_wildcards <= '0;
			cfg_q.pattern_length <= nwbpm_pkg::LEN_W'(1);
			cfg_q.pattern_valid <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_sel)
				nwbpm_pkg::REG_PATTERN_BYTES: cfg_q.pattern_bytes <= pwdata;
				nwbpm_pkg::REG_NIBBLE_WILDCARDS: cfg_q.nibble_wildcards <= pwdata[15:0];
				nwbpm_pkg::REG_PATTERN_LENGTH:
					cfg_q.pattern_length <= pwdata[nwbpm_pkg::LEN_W-1:0];
				nwbpm_pkg::REG_PATTERN_VALID: cfg_q.pattern_valid <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (reg_sel)
			nwbpm_pkg::REG_PATTERN_BYTES: prdata = cfg_q.pattern_bytes;
			nwbpm_pkg::REG_NIBBLE_WILDCARDS:
				prdata = nwbpm_pkg::APB_DATA_W'(cfg_q.nibble_wildcards);
			nwbpm_pkg::REG_PATTERN_LENGTH:
				prdata = nwbpm_pkg::APB_DATA_W'(cfg_q.pattern_length);
			nwbpm_pkg::REG_PATTERN_VALID:
				prdata = nwbpm_pkg::APB_DATA_W'(cfg_q.pattern_valid);
			default: prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

@@ hdl/nwbpm_cell.sv @@
// One window cell: holds a byte of history, passes it on, compares its slot.
`default_nettype none
module nwbpm_cell #(
	parameter int CELL_INDEX = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic shift_en,
	input wire logic clear,
	input wire logic [7:0] byte_in,
	input wire logic [nwbpm_pkg::LEN_W-1:0] len,
	input wire logic [63:0] pattern_bytes,
	input wire logic [15:0] nibble_wildcards,
	output logic [7:0] byte_out,
	output logic hit
);
	logic [7:0] byte_q;
	logic [7:0] byte_next;
	logic [nwbpm_pkg::PAT_SEL_W-1:0] sel;
	logic [7:0] want;
	logic [1:0] wild;
	logic [7:0] keep;
	logic active;

	assign byte_next = clear ? 8'h00 : byte_in;
	assign byte_out = byte_q;

	// Byte k ago pairs with signature byte len-1-k
	assign active = len > nwbpm_pkg::LEN_W'(CELL_INDEX);
	assign sel = nwbpm_pkg::PAT_SEL_W'(len - nwbpm_pkg::LEN_W'(CELL_INDEX)
		- nwbpm_pkg::LEN_W'(1));
	assign want = pattern_bytes[{sel, 3'b000} +: 8];
	assign wild = nibble_wildcards[{sel, 1'b0} +: 2];

	// Masked compare against the value this cell takes on the beat
	always_comb begin
		keep = 8'hFF;
		if (wild[0]) keep = keep & nwbpm_pkg::NIBBLE_LO_MASK;
		if (wild[1]) keep = keep & nwbpm_pkg::NIBBLE_HI_MASK;
		hit = !active || ((byte_next & keep) == (want & keep));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift_en) begin
			byte_q <= byte_next;
		end
	end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the nibble wildcard byte pattern matcher: directed table, then random streams.
`timescale 1ns / 100ps

module tb;
	localparam int CLK_HALF = 2;
	localparam int WIN = nwbpm_pkg::MAX_PATTERN_BYTES_DEF;
	localparam int DIR_ROWS = 25;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_BEATS = 77;
	localparam int HOLD_PHASE = 5;
	localparam int PAUSE_PHASE = 7;
	localparam int LONG_HOLD = 200;
	localparam int SETTLE = 4;

	// One result beat as the checker sees it
	typedef struct packed {
		logic match;
		logic [31:0] index;
	} match_beat_t;

	// Directed row: config preset, byte, restart flag, optional typed-in result
	typedef struct packed {
		logic [2:0] preset;
		logic [7:0] data;
		logic restart;
		logic typed;
		logic want_match;
		logic [31:0] want_index;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [nwbpm_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [nwbpm_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [nwbpm_pkg::APB_DATA_W-1:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00; // [7:0] data_byte
	logic s_tuser = 1'b0; // [0] restart
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata; // [0] match, [32:1] byte_index, [39:33] zero

	nibble_wildcard_byte_pattern_matcher uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #(CLK_HALF) clk = ~clk;

	// Predictor state: config copy, byte window, fill depth, next index
	nwbpm_pkg::cfg_t cfg_shadow = '{64'h0, 16'h0, 4'd1, 1'b0};
	logic [7:0] seen_bytes [WIN];
	int unsigned fill_depth = 0;
	logic [31:0] next_index = '0;

	match_beat_t pending_results [$];
	int fail_count = 0;
	int beats_sent = 0;
	bit sender_quiet = 1'b0;
	int hold_req = 0;

	initial begin
		foreach (seen_bytes[k])
			seen_bytes[k] = 8'h00;
	end

	// Directed stimulus: reset state, plain match, nibble wildcards with a short
	// window, zero length, oversize length with fully wild bytes, pattern not valid
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{3'd0, 8'h00, 1'b1, 1'b1, 1'b0, 32'd0},
		'{3'd0, 8'hFF, 1'b0, 1'b1, 1'b0, 32'd1},
		'{3'd1, 8'hDE, 1'b1, 1'b0, 1'b0, 32'd0},
		'{3'd1, 8'hAD, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd1, 8'hBE, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd1, 8'hEF, 1'b0, 1'b1, 1'b1, 32'd3},
		'{3'd2, 8'h3A, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd2, 8'hA7, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd2, 8'hFA, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd2, 8'hA5, 1'b1, 1'b1, 1'b0, 32'd0},
		'{3'd3, 8'h00, 1'b1, 1'b1, 1'b1, 32'd0},
		'{3'd3, 8'h01, 1'b0, 1'b1, 1'b0, 32'd1},
		'{3'd3, 8'h00, 1'b0, 1'b1, 1'b1, 32'd2},
		'{3'd4, 8'hFF, 1'b1, 1'b0, 1'b0, 32'd0},
		'{3'd4, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd4, 8'h33, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd4, 8'h44, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd4, 8'h55, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd4, 8'h66, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd4, 8'h77, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd4, 8'h88, 1'b0, 1'b1, 1'b1, 32'd7},
		'{3'd5, 8'hDE, 1'b1, 1'b0, 1'b0, 32'd0},
		'{3'd5, 8'hAD, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd5, 8'hBE, 1'b0, 1'b0, 1'b0, 32'd0},
		'{3'd5, 8'hEF, 1'b0, 1'b1, 1'b0, 32'd3}
	};

	nwbpm_pkg::cfg_t presets [6] = '{
		'{64'h0000_0000_0000_0000, 16'h0000, 4'd1, 1'b0},
		'{64'h0000_0000_EFBE_ADDE, 16'h0000, 4'd4, 1'b1},
		'{64'h0000_0000_0000_A55A, 16'h0009, 4'd2, 1'b1},
		'{64'hFFFF_FFFF_FFFF_FF00, 16'hFFFC, 4'd0, 1'b1},
		'{64'h8877_6655_4433_2211, 16'h000F, 4'd15, 1'b1},
		'{64'h0000_0000_EFBE_ADDE, 16'h0000, 4'd4, 1'b0}
	};

	function automatic int unsigned eff_length(input logic [3:0] len);
		if (len == 4'd0)
			return 1;
		if (len > WIN)
			return WIN;
		return len;
	endfunction

	// Shift one byte into the window and work out its match flag and index
	function automatic match_beat_t predict_match(input logic [7:0] data, input logic restart);
		match_beat_t res;
		int unsigned eff;
		logic [7:0] keep;
		logic [1:0] wbits;
		int k;
		eff = eff_length(cfg_shadow.pattern_length);
		if (restart) begin
			for (k = 0; k < WIN; k++)
				seen_bytes[k] = 8'h00;
			fill_depth = 0;
			next_index = '0;
		end
		for (k = WIN - 1; k > 0; k--)
			seen_bytes[k] = seen_bytes[k-1];
		seen_bytes[0] = data;
		if (fill_depth < WIN)
			fill_depth++;
		res.index = next_index;
		next_index = next_index + 32'd1;
		res.match = cfg_shadow.pattern_valid && (fill_depth >= eff);
		// signature byte 0 lines up with the oldest byte in use
		for (k = 0; k < eff; k++) begin
			wbits = cfg_shadow.nibble_wildcards[2*k +: 2];
			keep = 8'hFF;
			if (wbits[0])
				keep = keep & nwbpm_pkg::NIBBLE_LO_MASK;
			if (wbits[1])
				keep = keep & nwbpm_pkg::NIBBLE_HI_MASK;
			if ((seen_bytes[eff-1-k] & keep) != (cfg_shadow.pattern_bytes[8*k +: 8] & keep))
				res.match = 1'b0;
		end
		return res;
	endfunction

	function automatic int sender_gap();
		int r;
		if (sender_quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Offer one byte, wait for the beat, record the expected result
	task automatic send_beat(input logic [7:0] data, input logic restart, input logic typed,
			input match_beat_t typed_res);
		match_beat_t res;
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= restart;
		do
			@(posedge clk);
		while (!s_tready);
		res = predict_match(data, restart);
		pending_results.insert(pending_results.size(), typed ? typed_res : res);
		beats_sent++;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every expected result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write followed by a read back of the same register
	task automatic reg_access(input logic [1:0] id, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {id, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== value) begin
			$display("%0t: reg %0d read expected %0h actual %0h", $time, id, value, prdata);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_config(input nwbpm_pkg::cfg_t c);
		reg_access(nwbpm_pkg::REG_PATTERN_BYTES, c.pattern_bytes);
		reg_access(nwbpm_pkg::REG_NIBBLE_WILDCARDS, {48'h0, c.nibble_wildcards});
		reg_access(nwbpm_pkg::REG_PATTERN_LENGTH, {60'h0, c.pattern_length});
		reg_access(nwbpm_pkg::REG_PATTERN_VALID, {63'h0, c.pattern_valid});
		cfg_shadow = c;
	endtask

	function automatic nwbpm_pkg::cfg_t rand_config();
		nwbpm_pkg::cfg_t c;
		int r;
		c.pattern_bytes = {$urandom(), $urandom()};
		r = $urandom_range(0, 9);
		if (r < 4)
			c.nibble_wildcards = 16'h0000;
		else if (r < 8)
			c.nibble_wildcards = 16'($urandom() & $urandom());
		else
			c.nibble_wildcards = 16'($urandom());
		if ($urandom_range(0, 9) < 7)
			c.pattern_length = 4'($urandom_range(1, WIN));
		else
			c.pattern_length = 4'($urandom_range(0, 15));
		c.pattern_valid = ($urandom_range(0, 19) != 0);
		return c;
	endfunction

	// Signature with random wildcard nibbles, sometimes one flipped bit
	task automatic send_signature();
		int unsigned eff;
		int k;
		int bad;
		logic [7:0] b;
		logic [1:0] w;
		logic rs;
		eff = eff_length(cfg_shadow.pattern_length);
		bad = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, eff - 1)) : -1;
		for (k = 0; k < eff; k++) begin
			b = cfg_shadow.pattern_bytes[8*k +: 8];
			w = cfg_shadow.nibble_wildcards[2*k +: 2];
			if (w[0])
				b[7:4] = 4'($urandom());
			if (w[1])
				b[3:0] = 4'($urandom());
			if (k == bad)
				b = b ^ (8'h01 << $urandom_range(0, 7));
			rs = (k == 0) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 49) == 0);
			send_beat(b, rs, 1'b0, '0);
		end
	endtask

	// Filler: random bytes mixed with stray signature bytes
	task automatic send_noise();
		int n;
		logic [7:0] b;
		logic rs;
		n = $urandom_range(1, 6);
		repeat (n) begin
			if ($urandom_range(0, 1))
				b = 8'($urandom());
			else
				b = cfg_shadow.pattern_bytes[8*$urandom_range(0, WIN - 1) +: 8];
			rs = ($urandom_range(0, 29) == 0);
			send_beat(b, rs, 1'b0, '0);
		end
	endtask

	// Result side ready: random segments, plus long holds on request
	int rdy_left = 0;
	bit rdy_level = 1'b0;
	int hold_seen = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rdy_left == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						rdy_level = 1'b1;
						rdy_left = $urandom_range(1, 40);
					end
					9: begin
						rdy_level = 1'b0;
						rdy_left = $urandom_range(8, 30);
					end
					default: begin
						rdy_level = 1'b0;
						rdy_left = $urandom_range(1, 3);
					end
				endcase
			end
			rdy_left--;
			m_tready <= rdy_level;
		end
	end

	// Result checker
	always @(posedge clk) begin
		match_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, match %0b index %0d",
					$time, m_tdata[0], m_tdata[32:1]);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.match) begin
					$display("%0t: match expected %0b actual %0b (index %0d)",
						$time, want.match, m_tdata[0], want.index);
					fail_count++;
				end
				if (m_tdata[32:1] !== want.index) begin
					$display("%0t: byte_index expected %0d actual %0d",
						$time, want.index, m_tdata[32:1]);
					fail_count++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		int cur_preset;
		int phase;
		int stop_at;
		bit paused;
		nwbpm_pkg::cfg_t c;
		match_beat_t want;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; preset 0 is the reset configuration
		cur_preset = 0;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].preset != cur_preset) begin
				drain_results();
				cur_preset = dir_rows[r].preset;
				apply_config(presets[cur_preset]);
			end
			want.match = dir_rows[r].want_match;
			want.index = dir_rows[r].want_index;
			send_beat(dir_rows[r].data, dir_rows[r].restart, dir_rows[r].typed, want);
		end

		// random phases, each under its own configuration
		paused = 1'b0;
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			drain_results();
			c = rand_config();
			case (phase)
				0: c = '{64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 4'd8, 1'b1};
				1: c = '{64'h0000_0000_0000_0000, 16'hFFFF, 4'd1, 1'b1};
				2: c.pattern_length = 4'd0;
				3: c.pattern_length = 4'd15;
				4: c.pattern_valid = 1'b0;
				default: ;
			endcase
			apply_config(c);
			sender_quiet = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
			// receiver holds off while the sender keeps pushing
			if (phase == HOLD_PHASE)
				hold_req++;
			stop_at = beats_sent + PHASE_BEATS;
			while (beats_sent < stop_at) begin
				if (phase == PAUSE_PHASE && !paused && beats_sent >= stop_at - PHASE_BEATS / 2) begin
					drain_results();
					paused = 1'b1;
				end
				if ($urandom_range(0, 99) < 55)
					send_signature();
				else
					send_noise();
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Run limit
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end
endmodule
